/* sv/lta_pkg.sv */
// Package with widths, register indexes and fixed-point helpers for the atom update pipeline.
`timescale 1ns / 1ps
package lta_pkg;

   localparam int NUM_STAGES = 13;
   localparam int LAST_STAGE = NUM_STAGES - 1;
   localparam int SQRT_STAGES = 6;

   typedef enum logic [1:0] {
      CSR_VEL_SCALE   = 2'd0,
      CSR_NOISE_SCALE = 2'd1,
      CSR_HALF_STEP   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [25:0] rem;
      logic [23:0] root;
   } sqrt_type;

   // Q16.16 rounding, half up: floor((x + 2^15) / 2^16).
   function automatic logic signed [63:0] round16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x + 64'sd32768;
      return y >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   // Four digits of the bit-pair square root; each digit consumes two radicand bits.
   function automatic sqrt_type sqrt_step4(input sqrt_type cur, input logic [7:0] bits);
      sqrt_type    nxt;
      logic [27:0] shifted;
      logic [27:0] trial;
      nxt = cur;
      for (int i = 0; i < 4; i++) begin
         shifted = {nxt.rem, bits[7 - 2 * i -: 2]};
         trial   = {2'b00, nxt.root, 2'b01};
         if (shifted >= trial) begin
            nxt.rem  = 26'(shifted - trial);
            nxt.root = {nxt.root[22:0], 1'b1};
         end else begin
            nxt.rem  = shifted[25:0];
            nxt.root = {nxt.root[22:0], 1'b0};
         end
      end
      return nxt;
   endfunction

endpackage

/* sv/langevin_thermostat_atom_update.sv */
// Top level of the Langevin middle-step atom update pipeline.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_ready   velocity, inverse mass, noise, last_atom
//  rsp_      out        rsp_valid/rsp_ready   new velocity, displacement, updated, last_out
//  csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
//  One atom enters per cycle while the output is not stalled; each result passes the
//  six square-root stages and the chain of three multiplies before it appears.
//  Reset is synchronous and clears the valid bits and the registers to their defaults.
//  When the output register holds a result that is not taken, the whole pipeline
//  holds and req_ready drops, so no transaction is lost or repeated.
//
module langevin_thermostat_atom_update
   import lta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic        [30:0] req_inv_mass,
   input  logic signed [31:0] req_noise_x,
   input  logic signed [31:0] req_noise_y,
   input  logic signed [31:0] req_noise_z,
   input  logic               req_last_atom,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic signed [31:0] rsp_disp_x,
   output logic signed [31:0] rsp_disp_y,
   output logic signed [31:0] rsp_disp_z,
   output logic               rsp_updated,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_data
);

   // Everything one atom carries down the pipe. Fields fill in as stages are passed.
   typedef struct packed {
      logic [2:0][31:0] vel;
      logic [2:0][31:0] noise;
      logic             fixed;
      logic             last;
      logic [47:0]      radicand;
      sqrt_type         sq;
      logic [2:0][63:0] hv;    // half_step * v, raw then rounded
      logic [2:0][63:0] sv;    // vel_scale * v, raw then rounded
      logic [63:0]      amp;   // noise amplitude, raw then rounded and saturated
      logic [2:0][63:0] np;    // amplitude * noise
      logic [2:0][31:0] nv;    // saturated new velocity
      logic [2:0][63:0] hn;    // half_step * new velocity
      logic [2:0][31:0] disp;
   } pipe_type;

   logic [16:0] vel_scale_ff;
   logic [30:0] noise_scale_ff;
   logic [30:0] half_step_ff;

   pipe_type pipe_ff [NUM_STAGES];
   pipe_type pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic                  advance;

   // The pipe moves as one; it stops only when the output register is full and stalled.
   assign advance   = !valid_ff[LAST_STAGE] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_comb begin
      logic signed [63:0] hs;
      logic signed [63:0] vs;
      logic signed [63:0] t;
      hs = $signed({33'd0, half_step_ff});
      vs = $signed({47'd0, vel_scale_ff});

      pipe_in[0]          = pipe_ff[0];
      pipe_in[0].vel      = {req_vel_z, req_vel_y, req_vel_x};
      pipe_in[0].noise    = {req_noise_z, req_noise_y, req_noise_x};
      pipe_in[0].fixed    = (req_inv_mass == 31'd0);
      pipe_in[0].last     = req_last_atom;
      pipe_in[0].radicand = {1'b0, req_inv_mass, 16'd0};
      pipe_in[0].sq       = '0;
      for (int k = 1; k < NUM_STAGES; k++) begin
         pipe_in[k] = pipe_ff[k - 1];
      end

      // Square root of inv_mass * 2^16, one byte of radicand per stage.
      for (int k = 1; k <= SQRT_STAGES; k++) begin
         pipe_in[k].sq = sqrt_step4(pipe_ff[k - 1].sq,
                                    pipe_ff[k - 1].radicand[55 - 8 * k -: 8]);
      end

      // The velocity terms are formed while the root is still being worked out.
      for (int i = 0; i < 3; i++) begin
         pipe_in[1].hv[i] = hs * $signed({{32{pipe_ff[0].vel[i][31]}}, pipe_ff[0].vel[i]});
         pipe_in[1].sv[i] = vs * $signed({{32{pipe_ff[0].vel[i][31]}}, pipe_ff[0].vel[i]});
         pipe_in[2].hv[i] = round16($signed(pipe_ff[1].hv[i]));
         pipe_in[2].sv[i] = round16($signed(pipe_ff[1].sv[i]));
      end

      pipe_in[7].amp = {9'd0, 55'(noise_scale_ff) * 55'(pipe_ff[6].sq.root)};
      t = round16($signed(pipe_ff[7].amp));
      pipe_in[8].amp = (t > 64'sd2147483647) ? 64'd2147483647 : t;

      for (int i = 0; i < 3; i++) begin
         pipe_in[9].np[i]  = $signed(pipe_ff[8].amp)
                           * $signed({{32{pipe_ff[8].noise[i][31]}}, pipe_ff[8].noise[i]});
         pipe_in[10].nv[i] = sat32($signed(pipe_ff[9].sv[i]) + round16($signed(pipe_ff[9].np[i])));
         pipe_in[11].hn[i] = hs * $signed({{32{pipe_ff[10].nv[i][31]}}, pipe_ff[10].nv[i]});
         if (pipe_ff[11].fixed) begin
            // A fixed atom keeps its velocity and does not move.
            pipe_in[12].nv[i]   = pipe_ff[11].vel[i];
            pipe_in[12].disp[i] = '0;
         end else begin
            pipe_in[12].disp[i] = sat32($signed(pipe_ff[11].hv[i])
                                        + round16($signed(pipe_ff[11].hn[i])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         vel_scale_ff   <= 17'd65536;
         noise_scale_ff <= '0;
         half_step_ff   <= '0;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[NUM_STAGES-2:0], req_valid};
         end
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_VEL_SCALE:   vel_scale_ff   <= csr_data[16:0];
               CSR_NOISE_SCALE: noise_scale_ff <= csr_data[30:0];
               CSR_HALF_STEP:   half_step_ff   <= csr_data[30:0];
               default: ;
            endcase
         end
      end
      if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid     = valid_ff[LAST_STAGE];
   assign rsp_new_vel_x = pipe_ff[LAST_STAGE].nv[0];
   assign rsp_new_vel_y = pipe_ff[LAST_STAGE].nv[1];
   assign rsp_new_vel_z = pipe_ff[LAST_STAGE].nv[2];
   assign rsp_disp_x    = pipe_ff[LAST_STAGE].disp[0];
   assign rsp_disp_y    = pipe_ff[LAST_STAGE].disp[1];
   assign rsp_disp_z    = pipe_ff[LAST_STAGE].disp[2];
   assign rsp_updated   = !pipe_ff[LAST_STAGE].fixed;
   assign rsp_last_out  = pipe_ff[LAST_STAGE].last;

`ifndef NO_ASSERTIONS
   // A fixed atom must leave with zero displacement.
   a_fixed_no_disp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_updated |-> rsp_disp_x == 0 && rsp_disp_y == 0 && rsp_disp_z == 0)
      else $error("fixed atom has nonzero displacement");

   // The input side stalls exactly when a finished result waits.
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output stall");

   // A stalled result does not slip away while the pipe holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_disp_x))
      else $error("stalled result changed");
`endif

endmodule

/* test/tb.sv */
// Testbench for the Langevin atom update pipeline: random and directed atoms checked against a predictor.
`timescale 1ns / 1ps
module tb
   import lta_pkg::*;
();

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Input channel.
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic        [30:0] req_inv_mass = '0;
   logic signed [31:0] req_noise_x = '0, req_noise_y = '0, req_noise_z = '0;
   logic               req_last_atom = 1'b0;
   // Result channel.
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic signed [31:0] rsp_disp_x, rsp_disp_y, rsp_disp_z;
   logic               rsp_updated, rsp_last_out;
   // Register write channel.
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic        [1:0]  csr_index = '0;
   logic        [31:0] csr_data = '0;

   langevin_thermostat_atom_update dut (.*);

   // One atom as sent, and one expected atom result.
   typedef struct {
      logic signed [31:0] vel[3];
      logic        [30:0] inv_mass;
      logic signed [31:0] noise[3];
      logic               last_atom;
   } atom_type;

   typedef struct {
      logic signed [31:0] vel[3];
      logic signed [31:0] disp[3];
      logic               updated;
      logic               last_out;
   } atom_result_type;

   // The testbench's own copy of the registers.
   logic [16:0] friction_gain;
   logic [30:0] noise_amp;
   logic [30:0] half_dt;

   atom_result_type pending_atoms[$];
   int              errors = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;

   // Round half up from Q32.32 products to Q16.16.
   function automatic longint q16_round(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic atom_result_type predict_atom(input atom_type a);
      atom_result_type r;
      longint unsigned root;
      longint          amp, v, nz, d, nv;
      r.updated  = (a.inv_mass != 0);
      r.last_out = a.last_atom;
      if (a.inv_mass == 0) begin
         for (int i = 0; i < 3; i++) begin
            r.vel[i]  = a.vel[i];
            r.disp[i] = '0;
         end
         return r;
      end
      root = int_sqrt(longint'(a.inv_mass) << 16);
      amp  = q16_round(longint'(longint'(noise_amp) * root));
      if (amp > 64'sd2147483647) amp = 64'sd2147483647;
      for (int i = 0; i < 3; i++) begin
         v  = a.vel[i];
         nz = a.noise[i];
         d  = q16_round(longint'(half_dt) * v);
         nv = clamp32(q16_round(longint'(friction_gain) * v) + q16_round(amp * nz));
         d  = d + q16_round(longint'(half_dt) * nv);
         r.vel[i]  = nv[31:0];
         r.disp[i] = 32'(clamp32(d));
      end
      return r;
   endfunction

   // Writes one register between phases; the local copy follows the write.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VEL_SCALE:   friction_gain = value[16:0];
         CSR_NOISE_SCALE: noise_amp = value[30:0];
         CSR_HALF_STEP:   half_dt = value[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Sends one atom, idling beforehand as the current phase asks.
   task automatic send_atom(input atom_type a);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_vel_x     <= a.vel[0];
      req_vel_y     <= a.vel[1];
      req_vel_z     <= a.vel[2];
      req_inv_mass  <= a.inv_mass;
      req_noise_x   <= a.noise[0];
      req_noise_y   <= a.noise[1];
      req_noise_z   <= a.noise[2];
      req_last_atom <= a.last_atom;
      do @(posedge clock); while (!req_ready);
      pending_atoms.push_back(predict_atom(a));
   endtask

   // Waits for every expected result, then lets the pipeline drain fully.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_atoms.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(131071) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic atom_type rand_atom();
      atom_type a;
      for (int i = 0; i < 3; i++) begin
         a.vel[i]   = rand_word();
         a.noise[i] = rand_word();
      end
      case ($urandom_range(4))
         0: a.inv_mass = '0;
         1: a.inv_mass = 31'h7fffffff;
         2: a.inv_mass = 31'($urandom_range(262143));
         default: a.inv_mass = 31'($urandom);
      endcase
      a.last_atom = 1'($urandom_range(1));
      return a;
   endfunction

   // The receiver stalls at random; the checker compares every accepted transaction.
   always @(posedge clock) begin
      atom_result_type e;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_atoms.size() == 0) begin
            $display("%0t: result with none expected", $time);
            errors++;
         end else begin
            e = pending_atoms.pop_front();
            if (rsp_new_vel_x !== e.vel[0] || rsp_new_vel_y !== e.vel[1] ||
                rsp_new_vel_z !== e.vel[2] || rsp_disp_x !== e.disp[0] ||
                rsp_disp_y !== e.disp[1] || rsp_disp_z !== e.disp[2] ||
                rsp_updated !== e.updated || rsp_last_out !== e.last_out) begin
               $display("%0t: expected vel %h %h %h disp %h %h %h upd %b last %b", $time,
                        e.vel[0], e.vel[1], e.vel[2], e.disp[0], e.disp[1], e.disp[2],
                        e.updated, e.last_out);
               $display("%0t: actual   vel %h %h %h disp %h %h %h upd %b last %b", $time,
                        rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z, rsp_disp_x,
                        rsp_disp_y, rsp_disp_z, rsp_updated, rsp_last_out);
               errors++;
            end
         end
      end
   end

   // Field extremes, fixed atoms and the unused register index.
   task automatic test_directed();
      atom_type a;
      write_reg(CSR_NOISE_SCALE, 32'h0001_0000);
      write_reg(CSR_HALF_STEP, 32'h0000_8000);
      write_reg(CSR_UNUSED, 32'hffff_ffff);
      for (int k = 0; k < 20; k++) begin
         for (int i = 0; i < 3; i++) begin
            a.vel[i]   = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
            a.noise[i] = (k % 3 == 0) ? 32'sh80000000 : 32'sh7fffffff;
         end
         a.vel[1]   = k * 32'sh0001_0000 - 32'sh000a_0000;
         a.inv_mass = (k < 4) ? 31'd0 : (k < 8) ? 31'h7fffffff : 31'(k) << 14;
         a.last_atom = k[0];
         send_atom(a);
      end
      drain();
   endtask

   // Random atoms under one register setting and one idling pattern.
   task automatic test_random(input logic [31:0] gain, input logic [31:0] amp,
                              input logic [31:0] hdt, input int idle, input int stall,
                              input int count);
      write_reg(CSR_VEL_SCALE, gain);
      write_reg(CSR_NOISE_SCALE, amp);
      write_reg(CSR_HALF_STEP, hdt);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int k = 0; k < count; k++) begin
         send_atom(rand_atom());
         // Once, the sender holds off until the pipeline has emptied.
         if (k == count / 2 && idle == 49) begin
            req_valid <= 1'b0;
            while (pending_atoms.size() != 0) @(posedge clock);
         end
      end
      drain();
   endtask

   initial begin
      friction_gain = 17'd65536;
      noise_amp     = '0;
      half_dt       = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(32'd62000, 32'h0000_4000, 32'h0000_0800, 0, 0, 80);
      test_random(32'd0, 32'h0000_0000, 32'h0000_0000, 49, 0, 60);
      test_random(32'h1ffff, 32'h7fffffff, 32'h7fffffff, 0, 49, 80);
      test_random(32'd65536, $urandom, $urandom, 28, 28, 80);
      test_random($urandom, $urandom_range(1 << 20), $urandom_range(1 << 18), 0, 0, 80);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/lta_pkg.sv
sv/langevin_thermostat_atom_update.sv
test/tb.sv
